[rtl/core/m127_pkg.sv]
// shared constants, command codes and reduction helpers for the p = 2^127-1 field unit
package m127_pkg;

  localparam int unsigned W = 128;
  localparam logic [W-1:0] P128 = {1'b0, {(W-1){1'b1}}};

  localparam logic [3:0] CMD_ADD  = 4'd0;
  localparam logic [3:0] CMD_SUB  = 4'd1;
  localparam logic [3:0] CMD_NEG  = 4'd2;
  localparam logic [3:0] CMD_MUL  = 4'd3;
  localparam logic [3:0] CMD_TOM  = 4'd4;
  localparam logic [3:0] CMD_FROM = 4'd5;
  localparam logic [3:0] CMD_INV  = 4'd6;
  localparam logic [3:0] CMD_LEG  = 4'd7;
  localparam logic [3:0] CMD_SQRT = 4'd8;

  // fold bit 127 and bring any 128-bit value below p
  function automatic logic [W-2:0] red128(input logic [W-1:0] x);
    logic [W-1:0] y;
    logic [W-1:0] d;
    y = {1'b0, x[W-2:0]} + {{(W-1){1'b0}}, x[W-1]};
    d = y - P128;
    red128 = (y >= P128) ? d[W-2:0] : y[W-2:0];
  endfunction

  // x/2 mod p for x below p
  function automatic logic [W-2:0] half127(input logic [W-2:0] x);
    logic [W-1:0] s;
    s = x[0] ? ({1'b0, x} + P128) : {1'b0, x};
    half127 = s[W-1:1];
  endfunction

endpackage

[rtl/core/m127_mmul.sv]
// iterative montgomery multiplier: 32x32 partial products, mersenne fold, halving
module m127_mmul (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [m127_pkg::W-1:0] x_i,
  input  logic [m127_pkg::W-1:0] y_i,
  output logic                   done_o,
  output logic [m127_pkg::W-2:0] res_o
);
  import m127_pkg::*;

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_MUL  = 3'd1;
  localparam logic [2:0] U_DRN  = 3'd2;
  localparam logic [2:0] U_F1   = 3'd3;
  localparam logic [2:0] U_F2   = 3'd4;
  localparam logic [2:0] U_F3   = 3'd5;
  localparam logic [2:0] U_F4   = 3'd6;
  localparam logic [2:0] U_DONE = 3'd7;

  logic [2:0]     state_q, state_d;
  logic [3:0]     idx_q;
  logic           pv_q;
  logic [63:0]    pp_q;
  logic [2:0]     sh_q;
  logic [255:0]   acc_q;
  logic [129:0]   s1_q;
  logic [127:0]   t_q;
  logic [126:0]   red_q;
  logic [126:0]   res_q;
  logic [31:0]    xp, yp;
  logic [255:0]   acc_add;

  assign xp = x_i[{idx_q[3:2], 5'd0} +: 32];
  assign yp = y_i[{idx_q[1:0], 5'd0} +: 32];
  assign acc_add = acc_q + ({192'd0, pp_q} << {sh_q, 5'd0});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      U_IDLE: if (start_i) state_d = U_MUL;
      U_MUL:  if (idx_q == 4'd15) state_d = U_DRN;
      U_DRN:  state_d = U_F1;
      U_F1:   state_d = U_F2;
      U_F2:   state_d = U_F3;
      U_F3:   state_d = U_F4;
      U_F4:   state_d = U_DONE;
      U_DONE: state_d = U_IDLE;
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      idx_q   <= 4'd0;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == U_IDLE) begin
        idx_q <= 4'd0;
        pv_q  <= 1'b0;
      end else if (state_q == U_MUL) begin
        idx_q <= idx_q + 4'd1;
        pv_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      U_IDLE: acc_q <= '0;
      U_MUL: begin
        pp_q <= xp * yp;
        sh_q <= {1'b0, idx_q[3:2]} + {1'b0, idx_q[1:0]};
        if (pv_q) acc_q <= acc_add;
      end
      U_DRN: acc_q <= acc_add;
      // 2^127 = 1 mod p
      U_F1: s1_q <= {3'd0, acc_q[126:0]} + {1'b0, acc_q[255:127]};
      U_F2: t_q <= {1'b0, s1_q[126:0]} + {125'd0, s1_q[129:127]};
      U_F3: red_q <= red128(t_q);
      U_F4: res_q <= half127(red_q);
      default: ;
    endcase
  end

  assign done_o = (state_q == U_DONE);
  assign res_o  = res_q;

endmodule

[rtl/core/mersenne127_montgomery_field_alu_top.sv]
// top level of the p = 2^127-1 montgomery field unit
// One request at a time: in_stall_o stays high from acceptance until the result is loaded
// into the output register, and longer while an earlier result still waits there. Add, sub,
// neg and the conversion out of montgomery form reduce their operands and then finish without
// the multiplier. Each montgomery multiply runs on the one shared unit as a start step, 16
// 32x32 partial products, a drain step, four fold and halving steps and a done step: mul and
// to_mont take one multiply, sqrt 125 multiplies, inverse and legendre 254 multiplies each.
// The result register lets a finished result wait while the sequencer goes idle.
module mersenne127_montgomery_field_alu_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  command_i,
  input  logic [63:0] a_low_i,
  input  logic [63:0] a_high_i,
  input  logic [63:0] b_low_i,
  input  logic [63:0] b_high_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] c_low_o,
  output logic [62:0] c_high_o,
  output logic        nonresidue_o
);
  import m127_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_WSQ  = 3'd3;
  localparam logic [2:0] S_ML   = 3'd4;
  localparam logic [2:0] S_WML  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]   state_q;
  logic [3:0]   cmd_q;
  logic [127:0] a_q, b_q, r_q;
  logic [6:0]   cnt_q;
  logic         out_valid_q, nr_q;
  logic [63:0]  c_low_q;
  logic [62:0]  c_high_q;

  logic         mul_start, mul_done;
  logic [127:0] mul_y;
  logic [126:0] mul_res;
  logic         ebit, out_free, accept;
  logic [127:0] sum, dif;
  logic [126:0] c_simple;
  logic [126:0] c_fin;
  logic         is_pow;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign is_pow   = (cmd_q == CMD_INV) || (cmd_q == CMD_LEG) || (cmd_q == CMD_SQRT);

  assign mul_start = (state_q == S_SQ) || (state_q == S_ML);
  assign mul_y     = ((state_q == S_SQ) || (state_q == S_WSQ)) ? r_q : a_q;

  m127_mmul u_mmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .x_i    (r_q),
    .y_i    (mul_y),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  // exponent bits: p-2 clears bits 127 and 1, (p-1)/2 has bits 125..0 set
  always_comb begin
    case (cmd_q)
      CMD_INV: ebit = !((cnt_q == 7'd127) || (cnt_q == 7'd1));
      CMD_LEG: ebit = (cnt_q <= 7'd125);
      default: ebit = 1'b0;
    endcase
  end

  // a_q and b_q hold reduced operands here
  assign sum = a_q + b_q;
  assign dif = (a_q >= b_q) ? (a_q - b_q) : (a_q - b_q + P128);
  always_comb begin
    case (cmd_q)
      CMD_ADD:  c_simple = red128(sum);
      CMD_SUB:  c_simple = red128(dif);
      CMD_NEG:  c_simple = red128(P128 - a_q);
      CMD_FROM: c_simple = half127(a_q[126:0]);
      default:  c_simple = '0;
    endcase
  end

  always_comb begin
    c_fin = c_simple;
    if (cmd_q == CMD_LEG) c_fin = '0;
    else if (is_pow || cmd_q == CMD_MUL || cmd_q == CMD_TOM) c_fin = r_q[126:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_FIN && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: if (accept) begin
          unique case (command_i)
            CMD_MUL, CMD_TOM: state_q <= S_ML;
            CMD_INV, CMD_LEG, CMD_SQRT: state_q <= S_SQ;
            default: state_q <= S_RED;
          endcase
        end
        S_RED: state_q <= S_FIN;
        S_SQ:  state_q <= S_WSQ;
        S_WSQ: if (mul_done) begin
          if (cmd_q != CMD_SQRT && ebit) state_q <= S_ML;
          else if (cnt_q == 7'd0) state_q <= S_FIN;
          else state_q <= S_SQ;
        end
        S_ML:  state_q <= S_WML;
        S_WML: if (mul_done) begin
          if (!is_pow || cnt_q == 7'd0) state_q <= S_FIN;
          else state_q <= S_SQ;
        end
        S_FIN: if (out_free) begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      a_q   <= (command_i == CMD_MUL) ? {b_high_i, b_low_i} :
               (command_i == CMD_TOM) ? 128'd4 : {a_high_i, a_low_i};
      b_q   <= {b_high_i, b_low_i};
      r_q   <= ((command_i == CMD_INV) || (command_i == CMD_LEG)) ? 128'd2 :
               {a_high_i, a_low_i};
      cnt_q <= (command_i == CMD_SQRT) ? 7'd124 : 7'd127;
    end
    if (state_q == S_RED) begin
      a_q <= {1'b0, red128(a_q)};
      b_q <= {1'b0, red128(b_q)};
    end
    if (mul_done) r_q <= {1'b0, mul_res};
    if (mul_done && is_pow && cnt_q != 7'd0 &&
        ((state_q == S_WML) || (state_q == S_WSQ && !(cmd_q != CMD_SQRT && ebit)))) begin
      cnt_q <= cnt_q - 7'd1;
    end
    if (state_q == S_FIN && out_free) begin
      c_low_q  <= c_fin[63:0];
      c_high_q <= c_fin[126:64];
      nr_q     <= (cmd_q == CMD_LEG) ? r_q[0] : 1'b0;
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign c_low_o      = c_low_q;
  assign c_high_o     = c_high_q;
  assign nonresidue_o = nr_q;

endmodule

[rtl/core/m127_chk.sv]
// port-level checks for the field unit, bound to the top level
module m127_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] c_low_o,
  input logic [62:0] c_high_o,
  input logic        nonresidue_o
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(c_low_o) && $stable(c_high_o))
    else $error("result changed while stalled");

  // an accepted request blocks the input until it is done
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after request");

  // results are fully reduced
  a_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !((&c_high_o) && (&c_low_o)))
    else $error("result equals p");

  // legendre flag comes with zero element
  a_nr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && nonresidue_o |-> (c_low_o == 64'd0) && (c_high_o == 63'd0))
    else $error("nonresidue with nonzero element");

endmodule

bind mersenne127_montgomery_field_alu_top m127_chk u_m127_chk (.*);

[bench/tb_mersenne127_montgomery_field_alu_top.sv]
// testbench for the p = 2^127-1 montgomery field unit: directed and random requests
`timescale 1ns / 100ps

module tb_mersenne127_montgomery_field_alu_top;
  import m127_pkg::*;

  localparam logic [255:0] PRIME = {129'd0, {127{1'b1}}};
  localparam logic [127:0] P_FE = {1'b0, {127{1'b1}}};
  localparam logic [127:0] ALL_ONES = {128{1'b1}};
  localparam logic [127:0] INV_EXP = {1'b0, {125{1'b1}}, 2'b01};
  localparam logic [127:0] LEG_EXP = {2'b00, {126{1'b1}}};
  localparam logic [3:0] CMD_FIRST_UNKNOWN = CMD_SQRT + 4'd1;
  localparam logic [3:0] CMD_TOP = 4'hF;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned SETTLE_CYCLES = 50;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic [63:0] c_low;
    logic [62:0] c_high;
    logic        nonresidue;
  } field_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [3:0]  command_i = CMD_ADD;
  logic [63:0] a_low_i = '0;
  logic [63:0] a_high_i = '0;
  logic [63:0] b_low_i = '0;
  logic [63:0] b_high_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] c_low_o;
  logic [62:0] c_high_o;
  logic        nonresidue_o;

  field_result_t pending_results[$];
  int unsigned   mismatches = 0;
  int unsigned   cycles = 0;
  bit            quiet = 1'b0;
  bit            hold_toggle = 1'b0;
  bit            hold_seen = 1'b0;
  int unsigned   hold_left = 0;

  mersenne127_montgomery_field_alu_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .command_i, .a_low_i, .a_high_i,
    .b_low_i, .b_high_i, .out_valid_o, .out_stall_i, .c_low_o, .c_high_o, .nonresidue_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // field predictor
  function automatic logic [127:0] mod_p(input logic [255:0] x);
    logic [255:0] r;
    r = x % PRIME;
    return r[127:0];
  endfunction

  function automatic logic [127:0] halve_mod_p(input logic [127:0] x);
    logic [128:0] s;
    s = x[0] ? ({1'b0, x} + {1'b0, P_FE}) : {1'b0, x};
    return s[128:1];
  endfunction

  function automatic logic [127:0] mont_product(input logic [127:0] x, input logic [127:0] y);
    return halve_mod_p(mod_p({128'd0, x} * {128'd0, y}));
  endfunction

  function automatic logic [127:0] mont_power(input logic [127:0] x, input logic [127:0] e);
    logic [127:0] r;
    r = 128'd2;
    for (int i = 127; i >= 0; i--) begin
      r = mont_product(r, r);
      if (e[i]) r = mont_product(r, x);
    end
    return r;
  endfunction

  function automatic field_result_t predict_field_op(input logic [3:0] cmd,
                                                     input logic [127:0] a,
                                                     input logic [127:0] b);
    field_result_t res;
    logic [127:0] ra, rb, c, t;
    ra = mod_p({128'd0, a});
    rb = mod_p({128'd0, b});
    c = '0;
    res = '0;
    case (cmd)
      CMD_ADD:  c = mod_p({128'd0, ra} + {128'd0, rb});
      CMD_SUB:  c = mod_p({128'd0, ra} + {128'd0, P_FE} - {128'd0, rb});
      CMD_NEG:  c = mod_p({128'd0, P_FE} - {128'd0, ra});
      CMD_MUL:  c = mont_product(a, b);
      CMD_TOM:  c = mont_product(a, 128'd4);
      CMD_FROM: c = halve_mod_p(ra);
      CMD_INV:  c = mont_power(a, INV_EXP);
      CMD_LEG: begin
        t = mont_power(a, LEG_EXP);
        res.nonresidue = t[0];
      end
      CMD_SQRT: begin
        c = a;
        for (int i = 0; i < 125; i++) c = mont_product(c, c);
      end
      default: c = '0;
    endcase
    res.c_low = c[63:0];
    res.c_high = c[126:64];
    return res;
  endfunction

  // one request, valid left high on return
  task automatic send_request(input logic [3:0] cmd, input logic [127:0] a,
                              input logic [127:0] b);
    if (!quiet && $urandom_range(0, 99) < 31) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    command_i <= cmd;
    a_low_i <= a[63:0];
    a_high_i <= a[127:64];
    b_low_i <= b[63:0];
    b_high_i <= b[127:64];
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(predict_field_op(cmd, a, b));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [127:0] random_operand();
    case ($urandom_range(0, 5))
      0: return P_FE - 128'($urandom_range(0, 3)) + 128'($urandom_range(0, 3));
      1: return ALL_ONES - 128'($urandom_range(0, 3));
      2: return 128'($urandom_range(0, 15));
      default: return {$urandom, $urandom, $urandom, $urandom};
    endcase
  endfunction

  function automatic logic [3:0] random_command();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return 4'($urandom_range(CMD_INV, CMD_SQRT));
    if (roll < 10) return 4'($urandom_range(CMD_FIRST_UNKNOWN, CMD_TOP));
    return 4'($urandom_range(CMD_ADD, CMD_FROM));
  endfunction

  task automatic test_operand_extremes();
    logic [127:0] corner[5];
    corner = '{128'd0, 128'd1, P_FE - 128'd1, P_FE, ALL_ONES};
    for (int i = 0; i < 5; i++) begin
      send_request(CMD_ADD, corner[i], corner[4 - i]);
      send_request(CMD_SUB, corner[i], corner[(i + 2) % 5]);
    end
    send_request(CMD_SUB, 128'd0, P_FE - 128'd1);
    send_request(CMD_NEG, 128'd0, ALL_ONES);
    send_request(CMD_NEG, ALL_ONES, 128'd0);
    send_request(CMD_MUL, ALL_ONES, ALL_ONES);
    send_request(CMD_MUL, P_FE - 128'd1, 128'd2);
    send_request(CMD_TOM, ALL_ONES, ALL_ONES);
    send_request(CMD_FROM, 128'd1, ALL_ONES);
    send_request(CMD_FROM, ALL_ONES, 128'd0);
  endtask

  task automatic test_exponent_commands();
    send_request(CMD_INV, 128'd0, ALL_ONES);
    send_request(CMD_INV, 128'd2, 128'd0);
    send_request(CMD_LEG, 128'd0, 128'd0);
    send_request(CMD_LEG, P_FE - 128'd2, ALL_ONES);
    send_request(CMD_SQRT, ALL_ONES, 128'd0);
  endtask

  task automatic test_unknown_commands();
    send_request(CMD_FIRST_UNKNOWN, ALL_ONES, ALL_ONES);
    send_request(CMD_TOP, ALL_ONES, ALL_ONES);
  endtask

  task automatic test_random_mix(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      quiet = (i >= count / 3) && (i < count / 3 + 60);
      send_request(random_command(), random_operand(), random_operand());
    end
    quiet = 1'b0;
  endtask

  // receiver holds off while requests keep coming, then a full drain and one more multiply
  task automatic test_backpressure();
    hold_toggle = ~hold_toggle;
    for (int i = 0; i < 6; i++) begin
      send_request(4'($urandom_range(CMD_ADD, CMD_TOM)), random_operand(), random_operand());
    end
    drain_results();
    send_request(CMD_MUL, random_operand(), random_operand());
  endtask

  // receiver side
  always @(negedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 31);
    end
  end

  always @(posedge clk_i) begin
    field_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result c=%h_%h nr=%b",
                                       c_high_o, c_low_o, nonresidue_o);
      end else begin
        want = pending_results.pop_front();
        if (want.c_low !== c_low_o || want.c_high !== c_high_o ||
            want.nonresidue !== nonresidue_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected c=%h_%h nr=%b, got c=%h_%h nr=%b",
                     want.c_high, want.c_low, want.nonresidue,
                     c_high_o, c_low_o, nonresidue_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_operand_extremes();
    test_exponent_commands();
    test_unknown_commands();
    test_backpressure();
    test_random_mix(560);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
